### hw/rtl/pidinv_pkg.sv
// ----------------------------------------------------------------------------
// pidinv_pkg
// constants, register indexes and the clamp helper for the inverted-drive pid
// ----------------------------------------------------------------------------
package pidinv_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int SGAIN_W   = GAIN_W + 1;           // gain with sign applied
    localparam int DIFF_W    = DATA_W + 1;           // error and input delta
    localparam int PROD_W    = SGAIN_W + DIFF_W;     // one gain product
    localparam int INT_W     = DATA_W + FRAC_BITS + 1;
    localparam int SUM_W     = PROD_W + 2;           // p + i - d, no overflow
    localparam int DRIVE_W   = DATA_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_OUT_MIN   = 3'd4,
        REG_OUT_MAX   = 3'd5,
        REG_REVERSE   = 3'd6,
        REG_AUTO_MODE = 3'd7
    } t_reg_idx;

    // upper limit is tested first, so inverted limits behave as specified
    function automatic logic signed [SUM_W-1:0] clamp_sum(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] lo,
        input logic signed [SUM_W-1:0] hi
    );
        logic signed [SUM_W-1:0] res;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

### hw/rtl/pid_controller_inverted_output.sv
// ----------------------------------------------------------------------------
// pid_controller_inverted_output
// pid with derivative on measurement, clamped integral and inverted drive
// ----------------------------------------------------------------------------
// an input register and a result register lie between input beat and output
// beat; throughput: one beat per cycle while the output is not stalled, with
// the integral state updated in the result stage.
// reset (synchronous, active low) clears all registers and state to zero.
module pid_controller_inverted_output
    import pidinv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [DATA_W-1:0]      i_cfg_wdata,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,    // [15:0] measurement
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata     // [16:0] drive, [23:17] zero
);

    // configuration
    logic signed [DATA_W-1:0] r_setpoint;
    logic [GAIN_W-1:0]        r_gain_p;
    logic [GAIN_W-1:0]        r_gain_i;
    logic [GAIN_W-1:0]        r_gain_d;
    logic signed [DATA_W-1:0] r_out_min;
    logic signed [DATA_W-1:0] r_out_max;
    logic                     r_reverse;
    logic                     r_auto_mode;

    // controller state
    logic signed [DATA_W-1:0] r_latest;
    logic signed [INT_W-1:0]  r_integral;
    logic signed [DATA_W-1:0] r_last_output;
    logic                     r_was_auto;

    // pipeline
    logic                     r_in_valid;
    logic signed [DATA_W-1:0] r_in_meas;
    logic                     r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;

    logic advance;
    logic fire;

    assign advance    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - DRIVE_W){1'b0}}, r_drive};

    // ---------------------------------------------------------------- datapath
    logic signed [SGAIN_W-1:0] kp, ki, kd;
    logic signed [DIFF_W-1:0]  err, d_in;
    logic signed [PROD_W-1:0]  prod_p, prod_i, prod_d;
    logic signed [SUM_W-1:0]   lo_s, hi_s, lo_o, hi_o;
    logic signed [SUM_W-1:0]   int_base, int_new, raw, quot, out_s;
    logic signed [DATA_W-1:0]  n_last_output;
    logic signed [INT_W-1:0]   n_integral;
    logic signed [DRIVE_W-1:0] n_drive;

    always_comb begin
        kp = r_reverse ? -$signed({1'b0, r_gain_p}) : $signed({1'b0, r_gain_p});
        ki = r_reverse ? -$signed({1'b0, r_gain_i}) : $signed({1'b0, r_gain_i});
        kd = r_reverse ? -$signed({1'b0, r_gain_d}) : $signed({1'b0, r_gain_d});

        err  = DIFF_W'(r_setpoint) - DIFF_W'(r_in_meas);
        // previous sample always equals the last recorded measurement
        d_in = DIFF_W'(r_in_meas) - DIFF_W'(r_latest);

        prod_p = kp * err;
        prod_i = ki * err;
        prod_d = kd * d_in;

        lo_o = SUM_W'(r_out_min);
        hi_o = SUM_W'(r_out_max);
        lo_s = lo_o <<< FRAC_BITS;
        hi_s = hi_o <<< FRAC_BITS;

        // reseed the integral from the last output on entry into auto
        if (r_was_auto) begin
            int_base = SUM_W'(r_integral);
        end else begin
            int_base = clamp_sum(SUM_W'(r_last_output) <<< FRAC_BITS, lo_s, hi_s);
        end
        int_new = clamp_sum(int_base + SUM_W'(prod_i), lo_s, hi_s);

        raw = SUM_W'(prod_p) + int_new - SUM_W'(prod_d);
        // truncate toward zero
        if (raw < 0) begin
            quot = (raw + SUM_W'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
        end else begin
            quot = raw >>> FRAC_BITS;
        end
        out_s = clamp_sum(quot, lo_o, hi_o);

        n_integral    = int_new[INT_W-1:0];
        n_last_output = out_s[DATA_W-1:0];
        if (r_auto_mode) begin
            n_drive = DRIVE_W'(r_out_max) - DRIVE_W'(n_last_output);
        end else begin
            n_drive = DRIVE_W'(r_out_min);
        end
    end

    // limits after a write, used to pull the stored state inside them
    logic signed [DATA_W-1:0] n_out_min, n_out_max;
    logic signed [SUM_W-1:0]  cl_lo, cl_hi, cl_int, cl_last;
    logic                     lim_write;

    always_comb begin
        n_out_min = r_out_min;
        n_out_max = r_out_max;
        lim_write = 1'b0;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_OUT_MIN: begin
                    n_out_min = $signed(i_cfg_wdata);
                    lim_write = 1'b1;
                end
                REG_OUT_MAX: begin
                    n_out_max = $signed(i_cfg_wdata);
                    lim_write = 1'b1;
                end
                default: begin
                    lim_write = 1'b0;
                end
            endcase
        end
        cl_lo   = SUM_W'(n_out_min);
        cl_hi   = SUM_W'(n_out_max);
        cl_int  = clamp_sum(SUM_W'(r_integral), cl_lo <<< FRAC_BITS,
                            cl_hi <<< FRAC_BITS);
        cl_last = clamp_sum(SUM_W'(r_last_output), cl_lo, cl_hi);
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint    <= '0;
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_out_min     <= '0;
            r_out_max     <= '0;
            r_reverse     <= 1'b0;
            r_auto_mode   <= 1'b0;
            r_latest      <= '0;
            r_integral    <= '0;
            r_last_output <= '0;
            r_was_auto    <= 1'b0;
            r_in_valid    <= 1'b0;
            r_in_meas     <= '0;
            r_out_valid   <= 1'b0;
            r_drive       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SETPOINT:  r_setpoint  <= $signed(i_cfg_wdata);
                    REG_GAIN_P:    r_gain_p    <= i_cfg_wdata;
                    REG_GAIN_I:    r_gain_i    <= i_cfg_wdata;
                    REG_GAIN_D:    r_gain_d    <= i_cfg_wdata;
                    REG_OUT_MIN:   r_out_min   <= $signed(i_cfg_wdata);
                    REG_OUT_MAX:   r_out_max   <= $signed(i_cfg_wdata);
                    REG_REVERSE:   r_reverse   <= i_cfg_wdata[0];
                    REG_AUTO_MODE: r_auto_mode <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
                if (i_s_tvalid) begin
                    r_in_meas <= $signed(i_s_tdata[DATA_W-1:0]);
                end
            end

            if (advance) begin
                r_out_valid <= r_in_valid;
            end

            if (fire) begin
                r_drive  <= n_drive;
                r_latest <= r_in_meas;
                if (r_auto_mode) begin
                    r_integral    <= n_integral;
                    r_last_output <= n_last_output;
                    r_was_auto    <= 1'b1;
                end else begin
                    r_was_auto    <= 1'b0;
                end
            end else if (lim_write) begin
                r_integral    <= cl_int[INT_W-1:0];
                r_last_output <= cl_last[DATA_W-1:0];
            end
        end
    end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// streaming testbench for the inverted-drive pid controller
//
// A queue-fed driver sends measurement beats, and a clocked monitor predicts
// the drive for every accepted beat and checks the output beats in order.
// Register writes are made only while the block is quiet. A directed opening
// covers manual and auto items, re-entry to auto, limit writes, reverse action
// and inverted limits. Random segments then follow with fresh settings.
// ----------------------------------------------------------------------------
module tb_top;
    import pidinv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = longint'(1) << FRAC_BITS;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [DATA_W-1:0]      i_cfg_wdata = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;    // [15:0] measurement
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;           // [16:0] drive, [23:17] zero

    pid_controller_inverted_output dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // controller settings and state as the block should hold them
    longint sp_r = 0, gp_r = 0, gi_r = 0, gd_r = 0, lo_r = 0, hi_r = 0;
    bit     rev_r = 0, auto_r = 0;
    longint latest_m = 0, prev_m = 0, integ = 0, last_out = 0;
    bit     was_auto = 0;

    logic [15:0] meas_q[$];     // measurements waiting to be sent
    logic [16:0] drive_q[$];    // drives expected, oldest first
    int          n_err = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          in_fire = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // upper limit tested first, so with inverted limits anything above out_max
    // becomes out_max and everything else out_min
    function automatic longint clampv(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void apply_reg(t_reg_idx idx, logic [15:0] v);
        case (idx)
            REG_SETPOINT:  sp_r = longint'($signed(v));
            REG_GAIN_P:    gp_r = longint'(v);
            REG_GAIN_I:    gi_r = longint'(v);
            REG_GAIN_D:    gd_r = longint'(v);
            REG_OUT_MIN, REG_OUT_MAX: begin
                if (idx == REG_OUT_MIN) lo_r = longint'($signed(v));
                else hi_r = longint'($signed(v));
                integ    = clampv(integ, lo_r * ONE, hi_r * ONE);
                last_out = clampv(last_out, lo_r, hi_r);
            end
            REG_REVERSE:   rev_r = v[0];
            REG_AUTO_MODE: auto_r = v[0];
            default: ;
        endcase
    endfunction

    function automatic logic [16:0] predict_drive(logic [15:0] raw_in);
        longint m, kp, ki, kd, err, raw, outv, drv;
        m = longint'($signed(raw_in));
        if (!auto_r) begin
            latest_m = m;
            was_auto = 0;
            drv = lo_r;
            return drv[16:0];
        end
        // bumpless entry: reseed from the last manual sample and last output
        if (!was_auto) begin
            prev_m   = latest_m;
            integ    = clampv(last_out * ONE, lo_r * ONE, hi_r * ONE);
            was_auto = 1;
        end
        latest_m = m;
        kp = rev_r ? -gp_r : gp_r;
        ki = rev_r ? -gi_r : gi_r;
        kd = rev_r ? -gd_r : gd_r;
        err   = sp_r - m;
        integ = clampv(integ + ki * err, lo_r * ONE, hi_r * ONE);
        raw   = kp * err + integ - kd * (m - prev_m);
        outv  = clampv(raw / ONE, lo_r, hi_r);
        last_out = outv;
        prev_m   = m;
        drv = hi_r - outv;
        return drv[16:0];
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || in_fire) begin
            if (meas_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= meas_q.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: predict on input beats, check output beats
    always @(posedge i_clk) begin
        logic [16:0] want;
        in_fire = i_rst_n && i_s_tvalid && o_s_tready;
        if (in_fire) begin
            drive_q.push_back(predict_drive(i_s_tdata));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (drive_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("unexpected output beat, drive %0d", $signed(o_m_tdata[16:0]));
                end
            end else begin
                want = drive_q.pop_front();
                if (o_m_tdata !== {7'b0, want}) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("drive mismatch: expected %0d (0x%06h) got %0d (0x%06h)",
                                 $signed(want), {7'b0, want},
                                 $signed(o_m_tdata[16:0]), o_m_tdata);
                    end
                end
            end
        end
    end

    // sender holds off until every expected drive is back, then a short gap
    task automatic settle();
        while (meas_q.size() != 0 || drive_q.size() != 0 || i_s_tvalid) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // called at a falling edge; leaves the enable high for the caller to drop
    task automatic reg_write(t_reg_idx idx, logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        apply_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic set_all(logic [15:0] sp, logic [15:0] gp, logic [15:0] gi,
                           logic [15:0] gd, logic [15:0] lo, logic [15:0] hi,
                           bit rev, bit auto_on);
        reg_write(REG_SETPOINT, sp);
        reg_write(REG_GAIN_P, gp);
        reg_write(REG_GAIN_I, gi);
        reg_write(REG_GAIN_D, gd);
        reg_write(REG_OUT_MIN, lo);
        reg_write(REG_OUT_MAX, hi);
        reg_write(REG_REVERSE, 16'(rev));
        reg_write(REG_AUTO_MODE, 16'(auto_on));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 16'h0300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        logic signed [15:0] a, b, lo, hi;
        case ($urandom_range(0, 6))
            0: begin
                lo = -16'sd32768;
                hi = 16'sd32767;
            end
            1, 2: begin
                a = 16'($urandom);
                b = 16'($urandom);
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
            3, 4: begin
                lo = -16'($urandom_range(0, 500));
                hi = 16'($urandom_range(0, 500));
            end
            5: begin
                // inverted limits
                lo = 16'($urandom_range(0, 300));
                hi = -16'($urandom_range(0, 300));
            end
            default: begin
                lo = 16'($urandom_range(0, 200)) - 16'sd100;
                hi = lo;
            end
        endcase
        set_all(16'($urandom), pick_gain(), pick_gain(), pick_gain(), lo, hi,
                1'($urandom_range(0, 1)), ($urandom_range(0, 99) < 80));
    endtask

    initial begin
        logic [15:0] m;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 76;

        // manual items drive out_min and only record the measurement
        set_all(16'h7FFF, 16'h0100, 16'h0040, 16'h0080, 16'h8000, 16'h7FFF, 0, 0);
        meas_q.push_back(16'h8000);
        meas_q.push_back(16'h7FFF);
        settle();

        // entering auto, error extremes
        reg_write(REG_AUTO_MODE, 16'd1);
        i_cfg_we <= 1'b0;
        meas_q.push_back(16'h8000);
        meas_q.push_back(16'h7FFF);
        meas_q.push_back(16'h0000);
        meas_q.push_back(16'hFFFF);
        settle();

        // full-scale gains, saturation both ways
        reg_write(REG_SETPOINT, 16'h8000);
        reg_write(REG_GAIN_P, 16'hFFFF);
        reg_write(REG_GAIN_I, 16'hFFFF);
        reg_write(REG_GAIN_D, 16'hFFFF);
        i_cfg_we <= 1'b0;
        meas_q.push_back(16'h7FFF);
        meas_q.push_back(16'h8000);
        meas_q.push_back(16'h7FFF);
        settle();

        // narrowing the limits in auto clamps the integral and last output
        reg_write(REG_OUT_MIN, -16'sd100);
        reg_write(REG_OUT_MAX, 16'sd100);
        reg_write(REG_SETPOINT, 16'd0);
        reg_write(REG_GAIN_P, 16'h0100);
        reg_write(REG_GAIN_I, 16'h0100);
        reg_write(REG_GAIN_D, 16'h0000);
        i_cfg_we <= 1'b0;
        meas_q.push_back(16'd10);
        meas_q.push_back(-16'sd10);
        meas_q.push_back(16'd0);
        settle();

        reg_write(REG_REVERSE, 16'd1);
        i_cfg_we <= 1'b0;
        meas_q.push_back(16'd50);
        meas_q.push_back(-16'sd50);
        settle();

        // inverted limits
        reg_write(REG_OUT_MIN, 16'sd300);
        reg_write(REG_OUT_MAX, -16'sd300);
        i_cfg_we <= 1'b0;
        meas_q.push_back(16'd0);
        meas_q.push_back(16'd1000);
        meas_q.push_back(-16'sd1000);
        settle();

        // back to manual, then re-entry seeds from the last output
        reg_write(REG_AUTO_MODE, 16'd0);
        i_cfg_we <= 1'b0;
        meas_q.push_back(16'd1234);
        settle();
        reg_write(REG_OUT_MIN, -16'sd2000);
        reg_write(REG_OUT_MAX, 16'sd2000);
        reg_write(REG_AUTO_MODE, 16'd1);
        i_cfg_we <= 1'b0;
        meas_q.push_back(16'd1200);
        meas_q.push_back(16'd1300);
        settle();

        for (int seg = 0; seg < 15; seg++) begin
            if (seg == 5) begin
                send_idle_pct = 76;
                recv_idle_pct = 16;
            end else if (seg == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_setup();
            for (int k = 0; k < 30; k++) begin
                // mostly samples near the setpoint so the loop stays in range
                if ($urandom_range(0, 99) < 60) begin
                    m = 16'(sp_r + longint'($urandom_range(0, 512)) - 256);
                end else begin
                    m = 16'($urandom);
                end
                meas_q.push_back(m);
            end
            settle();
        end

        repeat (10) @(negedge i_clk);
        if (n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
hw/rtl/pidinv_pkg.sv
hw/rtl/pid_controller_inverted_output.sv
bench/tb_top.sv
